// ----- rtl/matrix_stack_4x4_defines.svh -----
// assertion macros for the matrix stack
`ifndef MATRIX_STACK_4X4_DEFINES_SVH
`define MATRIX_STACK_4X4_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MSTK_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MSTK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSTK_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define MSTK_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ----- rtl/mstk_pkg.sv -----
// shared constants and command types for the matrix stack
`timescale 1ns / 1ps

package mstk_pkg;

  localparam int STACK_DEPTH   = 16;
  localparam int FRACTION_BITS = 16;

  localparam int ENTRY_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int COUNT_W   = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W    = ENTRY_W + 4;
  localparam int MEM_DEPTH = STACK_DEPTH * 16;
  localparam int ACC_W     = 66;

  localparam logic [31:0] FIX_ONE = 32'd1 << FRACTION_BITS;

  // operation codes
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_MUL  = 2'd1;
  localparam logic [1:0] OP_POP  = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // memory write data select
  localparam logic [1:0] WSEL_IDENT = 2'd0;
  localparam logic [1:0] WSEL_BUF   = 2'd1;
  localparam logic [1:0] WSEL_MAC   = 2'd2;

  typedef struct packed {
    logic               buf_wr;
    logic [3:0]         buf_idx;
    logic               mem_we;
    logic               mem_re;
    logic [ENTRY_W-1:0] mem_entry;
    logic [3:0]         mem_elem;
    logic [1:0]         wsel;
    logic               row_ld;
    logic [1:0]         row_k;
    logic               mul_en;
    logic [1:0]         mul_k;
    logic               acc_en;
    logic               acc_first;
    logic               out_ld;
    logic               out_from_mem;
    logic [3:0]         out_index;
    logic               out_last;
    logic [1:0]         out_status;
    logic [4:0]         out_depth;
  } mstk_cmd_t;

  typedef struct packed {
    logic out_free;
  } mstk_sts_t;

endpackage

// ----- rtl/matrix_stack_4x4.sv -----
// Stack of 4x4 Q16.16 transform matrices with push, multiply, pop and read.
// The item channel (item_valid/item_stall) carries operation, element_index
// and element_value; the result channel (result_valid/result_stall) carries
// result_value, result_index, last_of_run, status and depth_in_use.
// Push and multiply send a matrix one element per transaction; each element
// before element 15 gives one result in the cycle after it is taken. On
// element 15 a push copies the buffer into the new top element by element;
// a multiply runs 64 multiply-accumulates through one 32x32 multiplier: per
// row it loads a row of the top matrix from memory, then per element sums
// four products and writes back the saturated sum; both then answer. Pop
// answers in the cycle after it is taken. Read returns the 16 top elements
// one by one, bounded by the single memory port. One item is worked at a time;
// item_stall stays high until it is finished. Reset writes the identity into
// the bottom entry, with item_stall high, then leaves one entry on the stack.
// A stalled result is held; no new item is taken while it waits.
`timescale 1ns / 1ps
`include "matrix_stack_4x4_defines.svh"

module matrix_stack_4x4 (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         operation,
  input  logic [3:0]         element_index,
  input  logic signed [31:0] element_value,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] result_value,
  output logic [3:0]         result_index,
  output logic               last_of_run,
  output logic [1:0]         status,
  output logic [4:0]         depth_in_use
);

  mstk_pkg::mstk_cmd_t cmd;
  mstk_pkg::mstk_sts_t sts;

  // sequencer
  mstk_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .operation     (operation),
    .element_index (element_index),
    .sts           (sts),
    .cmd           (cmd)
  );

  // storage and arithmetic
  mstk_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .element_index (element_index),
    .element_value (element_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result_value  (result_value),
    .result_index  (result_index),
    .last_of_run   (last_of_run),
    .status        (status),
    .depth_in_use  (depth_in_use)
  );

  // a transaction is only taken when its result has room
  `MSTK_ASSERT_IMPL(a_take_needs_room, clk, rst, item_valid && !item_stall, !result_valid || !result_stall, "item taken while a result is blocked")

  // a pending result is never overwritten
  `MSTK_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.out_ld, sts.out_free, "output register loaded while held")

  // only a successful read gives results that are not last
  `MSTK_ASSERT_IMPL(a_mid_read_ok, clk, rst, result_valid && !last_of_run, status == mstk_pkg::ST_OK && result_index != 4'd15, "bad non-final result")

  // plain elements answer on the next cycle
  `MSTK_ASSERT_NEXT(a_elem_next, clk, rst, item_valid && !item_stall && operation != mstk_pkg::OP_READ && operation != mstk_pkg::OP_POP && element_index != 4'd15, result_valid && last_of_run && status == mstk_pkg::ST_OK, "element result late")

endmodule

// ----- rtl/mstk_ctrl.sv -----
// controller state machine: sequences init, copy, multiply and readout
`timescale 1ns / 1ps

module mstk_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  logic [1:0]          operation,
  input  logic [3:0]          element_index,
  input  mstk_pkg::mstk_sts_t sts,
  output mstk_pkg::mstk_cmd_t cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_COPY   = 4'd2;
  localparam logic [3:0] S_MLOAD  = 4'd3;
  localparam logic [3:0] S_MMAC   = 4'd4;
  localparam logic [3:0] S_MWR    = 4'd5;
  localparam logic [3:0] S_RISSUE = 4'd6;
  localparam logic [3:0] S_RSEND  = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0]                   state, state_next;
  logic [3:0]                   idx, idx_next;
  logic [1:0]                   row, row_next;
  logic [1:0]                   col, col_next;
  logic [2:0]                   step, step_next;
  logic [mstk_pkg::COUNT_W-1:0] count, count_next;
  logic [mstk_pkg::COUNT_W-1:0] count_dec;
  logic [mstk_pkg::ENTRY_W-1:0] top_entry;
  logic                         full;

  // low five bits of the entry count
  function automatic logic [4:0] depth_field(input logic [mstk_pkg::COUNT_W-1:0] n);
    logic [mstk_pkg::COUNT_W+4:0] w;
    w = (mstk_pkg::COUNT_W + 5)'(n);
    return w[4:0];
  endfunction

  assign count_dec = count - mstk_pkg::COUNT_W'(1);
  assign top_entry = count_dec[mstk_pkg::ENTRY_W-1:0];
  assign full      = (count >= mstk_pkg::COUNT_W'(mstk_pkg::STACK_DEPTH));

  // next state and command decode
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    row_next       = row;
    col_next       = col;
    step_next      = step;
    count_next     = count;
    item_stall     = 1'b1;
    cmd            = '0;
    cmd.out_last   = 1'b1;
    cmd.out_status = mstk_pkg::ST_OK;
    cmd.out_depth  = depth_field(count);
    case (state)
      S_INIT: begin
        cmd.mem_we    = 1'b1;
        cmd.wsel      = mstk_pkg::WSEL_IDENT;
        cmd.mem_entry = '0;
        cmd.mem_elem  = idx;
        idx_next      = idx + 4'd1;
        if (idx == 4'd15) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_stall = !sts.out_free;
        if (item_valid && sts.out_free) begin
          if (operation inside {mstk_pkg::OP_PUSH, mstk_pkg::OP_MUL}) begin
            cmd.buf_wr    = 1'b1;
            cmd.out_index = element_index;
            if (element_index != 4'd15) begin
              cmd.out_ld = 1'b1;
            end else if (operation == mstk_pkg::OP_PUSH) begin
              if (full) begin
                cmd.out_ld     = 1'b1;
                cmd.out_status = mstk_pkg::ST_FULL;
              end else begin
                idx_next   = '0;
                state_next = S_COPY;
              end
            end else begin
              if (count == '0) begin
                cmd.out_ld     = 1'b1;
                cmd.out_status = mstk_pkg::ST_EMPTY;
              end else begin
                row_next   = '0;
                col_next   = '0;
                step_next  = '0;
                state_next = S_MLOAD;
              end
            end
          end else if (operation == mstk_pkg::OP_POP) begin
            cmd.out_ld = 1'b1;
            if (count == '0) begin
              cmd.out_status = mstk_pkg::ST_EMPTY;
            end else begin
              count_next    = count_dec;
              cmd.out_depth = depth_field(count_dec);
            end
          end else begin
            if (count == '0) begin
              cmd.out_ld     = 1'b1;
              cmd.out_status = mstk_pkg::ST_EMPTY;
            end else begin
              idx_next   = '0;
              state_next = S_RISSUE;
            end
          end
        end
      end
      // copy the incoming buffer into the new top entry
      S_COPY: begin
        cmd.mem_we    = 1'b1;
        cmd.wsel      = mstk_pkg::WSEL_BUF;
        cmd.buf_idx   = idx;
        cmd.mem_entry = count[mstk_pkg::ENTRY_W-1:0];
        cmd.mem_elem  = idx;
        idx_next      = idx + 4'd1;
        if (idx == 4'd15) begin
          count_next = count + mstk_pkg::COUNT_W'(1);
          state_next = S_RESP;
        end
      end
      // fetch one row of the top matrix into the row registers
      S_MLOAD: begin
        if (step != 3'd4) begin
          cmd.mem_re    = 1'b1;
          cmd.mem_entry = top_entry;
          cmd.mem_elem  = {row, step[1:0]};
        end
        if (step != 3'd0) begin
          cmd.row_ld = 1'b1;
          cmd.row_k  = step[1:0] - 2'd1;
        end
        if (step == 3'd4) begin
          step_next  = '0;
          state_next = S_MMAC;
        end else begin
          step_next = step + 3'd1;
        end
      end
      // four multiply-accumulates for one output element
      S_MMAC: begin
        if (step != 3'd4) begin
          cmd.mul_en  = 1'b1;
          cmd.mul_k   = step[1:0];
          cmd.buf_idx = {step[1:0], col};
        end
        if (step != 3'd0) begin
          cmd.acc_en    = 1'b1;
          cmd.acc_first = (step == 3'd1);
        end
        if (step == 3'd4) begin
          step_next  = '0;
          state_next = S_MWR;
        end else begin
          step_next = step + 3'd1;
        end
      end
      // write the saturated element back in place
      S_MWR: begin
        cmd.mem_we    = 1'b1;
        cmd.wsel      = mstk_pkg::WSEL_MAC;
        cmd.mem_entry = top_entry;
        cmd.mem_elem  = {row, col};
        col_next      = col + 2'd1;
        step_next     = '0;
        if (col == 2'd3) begin
          row_next = row + 2'd1;
          if (row == 2'd3) begin
            state_next = S_RESP;
          end else begin
            state_next = S_MLOAD;
          end
        end else begin
          state_next = S_MMAC;
        end
      end
      S_RISSUE: begin
        cmd.mem_re    = 1'b1;
        cmd.mem_entry = top_entry;
        cmd.mem_elem  = idx;
        state_next    = S_RSEND;
      end
      S_RSEND: begin
        if (sts.out_free) begin
          cmd.out_ld       = 1'b1;
          cmd.out_from_mem = 1'b1;
          cmd.out_index    = idx;
          cmd.out_last     = (idx == 4'd15);
          idx_next         = idx + 4'd1;
          if (idx == 4'd15) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_RISSUE;
          end
        end
      end
      // closing result of a completed push or multiply
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_ld    = 1'b1;
          cmd.out_index = 4'd15;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      idx   <= '0;
      row   <= '0;
      col   <= '0;
      step  <= '0;
      count <= mstk_pkg::COUNT_W'(1);
    end else begin
      state <= state_next;
      idx   <= idx_next;
      row   <= row_next;
      col   <= col_next;
      step  <= step_next;
      count <= count_next;
    end
  end

endmodule

// ----- rtl/mstk_dp.sv -----
// datapath: matrix memory, incoming buffer, multiplier, accumulator, output register
`timescale 1ns / 1ps

module mstk_dp (
  input  logic                clk,
  input  logic                rst,
  input  mstk_pkg::mstk_cmd_t cmd,
  output mstk_pkg::mstk_sts_t sts,
  input  logic [3:0]          element_index,
  input  logic signed [31:0]  element_value,
  output logic                result_valid,
  input  logic                result_stall,
  output logic signed [31:0]  result_value,
  output logic [3:0]          result_index,
  output logic                last_of_run,
  output logic [1:0]          status,
  output logic [4:0]          depth_in_use
);

  localparam logic signed [mstk_pkg::ACC_W-1:0] SAT_MAX =
    {{(mstk_pkg::ACC_W - 32){1'b0}}, 32'h7fff_ffff};
  localparam logic signed [mstk_pkg::ACC_W-1:0] SAT_MIN =
    {{(mstk_pkg::ACC_W - 32){1'b1}}, 32'h8000_0000};

  logic [31:0]                       mem [mstk_pkg::MEM_DEPTH];
  logic [31:0]                       mem_rdata;
  logic [mstk_pkg::ADDR_W-1:0]       addr;
  logic [31:0]                       wdata;
  logic signed [31:0]                buf_mem [16];
  logic signed [31:0]                buf_rd;
  logic signed [31:0]                row_reg [4];
  logic signed [63:0]                product;
  logic signed [mstk_pkg::ACC_W-1:0] acc;
  logic signed [mstk_pkg::ACC_W-1:0] acc_base;
  logic signed [mstk_pkg::ACC_W-1:0] shifted;
  logic [31:0]                       sat_value;

  assign addr   = {cmd.mem_entry, cmd.mem_elem};
  assign buf_rd = buf_mem[cmd.buf_idx];

  // floor shift and saturation of the accumulated sum
  assign shifted = acc >>> mstk_pkg::FRACTION_BITS;
  always_comb begin
    if (shifted > SAT_MAX) begin
      sat_value = SAT_MAX[31:0];
    end else if (shifted < SAT_MIN) begin
      sat_value = SAT_MIN[31:0];
    end else begin
      sat_value = shifted[31:0];
    end
  end

  // memory write data select
  always_comb begin
    case (cmd.wsel)
      mstk_pkg::WSEL_IDENT: begin
        wdata = (cmd.mem_elem[3:2] == cmd.mem_elem[1:0]) ? mstk_pkg::FIX_ONE : '0;
      end
      mstk_pkg::WSEL_BUF: begin
        wdata = buf_rd;
      end
      mstk_pkg::WSEL_MAC: begin
        wdata = sat_value;
      end
      default: begin
        wdata = '0;
      end
    endcase
  end

  // matrix memory, one port
  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[addr] <= wdata;
    end
    if (cmd.mem_re) begin
      mem_rdata <= mem[addr];
    end
  end

  // incoming element buffer
  always_ff @(posedge clk) begin
    if (cmd.buf_wr) begin
      buf_mem[element_index] <= element_value;
    end
  end

  // row registers, multiplier and accumulator
  assign acc_base = cmd.acc_first ? '0 : acc;
  always_ff @(posedge clk) begin
    if (cmd.row_ld) begin
      row_reg[cmd.row_k] <= mem_rdata;
    end
    if (cmd.mul_en) begin
      product <= row_reg[cmd.mul_k] * buf_rd;
    end
    if (cmd.acc_en) begin
      acc <= acc_base + {{(mstk_pkg::ACC_W - 64){product[63]}}, product};
    end
  end

  // output register
  assign sts.out_free = !result_valid || !result_stall;
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_ld) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      result_value <= cmd.out_from_mem ? mem_rdata : '0;
      result_index <= cmd.out_index;
      last_of_run  <= cmd.out_last;
      status       <= cmd.out_status;
      depth_in_use <= cmd.out_depth;
    end
  end

endmodule

// ----- sim/matrix_stack_4x4_test.sv -----
// self-checking testbench for the 4x4 transform matrix stack
`timescale 1ns / 1ps

module matrix_stack_4x4_test;
  import mstk_pkg::*;

  localparam logic [3:0] LAST_ELEM = 4'd15;
  localparam int CYCLE_LIMIT = 800000;
  localparam int RANDOM_ITEMS = 320;
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  typedef struct {
    logic signed [31:0] value;
    logic [3:0]         index;
    logic               last;
    logic [1:0]         stat;
    logic [4:0]         depth;
  } stack_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [1:0]         operation = OP_PUSH;
  logic [3:0]         element_index = 4'd0;
  logic signed [31:0] element_value = 32'sd0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [31:0] result_value;
  logic [3:0]         result_index;
  logic               last_of_run;
  logic [1:0]         status;
  logic [4:0]         depth_in_use;

  matrix_stack_4x4 dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .operation    (operation),
    .element_index(element_index),
    .element_value(element_value),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_value (result_value),
    .result_index (result_index),
    .last_of_run  (last_of_run),
    .status       (status),
    .depth_in_use (depth_in_use)
  );

  always #6 clk = ~clk;

  // stack model state
  logic signed [31:0] stack_mem [STACK_DEPTH][16];
  logic signed [31:0] pending_m [16];
  int depth_cnt;
  stack_result_t expected_results[$];

  // bookkeeping
  int error_count = 0;
  int results_checked = 0;
  int items_sent = 0;
  int push_elems = 0, mul_elems = 0, pop_items = 0, read_items = 0;
  int full_hits = 0, empty_hits = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;

  // receiver stall pattern state
  int stall_mode = 0, mode_left = 0, run_left = 0;
  bit stall_level = 1'b0;

  // one element of top times pending matrix, floor shift then saturate
  function automatic logic signed [31:0] fixed_dot(input int r, input int c);
    logic signed [65:0] acc;
    logic signed [65:0] shifted;
    longint prod;
    int k;
    acc = '0;
    for (k = 0; k < 4; k++) begin
      prod = longint'(stack_mem[depth_cnt-1][r*4+k]) * longint'(pending_m[k*4+c]);
      acc = acc + 66'(prod);
    end
    shifted = acc >>> FRACTION_BITS;
    if (shifted > SAT_HI) return 32'sh7fffffff;
    if (shifted < SAT_LO) return 32'sh80000000;
    return shifted[31:0];
  endfunction

  // apply one accepted transaction to the model and queue what it returns
  task automatic update_stack_model(input logic [1:0] op, input logic [3:0] idx,
                                    input logic signed [31:0] val);
    stack_result_t res;
    logic signed [31:0] product [16];
    int i;
    res.value = '0;
    res.index = 4'd0;
    res.last = 1'b1;
    res.stat = ST_OK;
    case (op)
      OP_PUSH, OP_MUL: begin
        if (op == OP_PUSH) push_elems++;
        else mul_elems++;
        pending_m[idx] = val;
        if (idx == LAST_ELEM) begin
          if (op == OP_PUSH) begin
            if (depth_cnt >= STACK_DEPTH) begin
              res.stat = ST_FULL;
              full_hits++;
            end else begin
              for (i = 0; i < 16; i++) stack_mem[depth_cnt][i] = pending_m[i];
              depth_cnt++;
            end
          end else if (depth_cnt == 0) begin
            res.stat = ST_EMPTY;
            empty_hits++;
          end else begin
            for (i = 0; i < 16; i++) product[i] = fixed_dot(i >> 2, i & 3);
            for (i = 0; i < 16; i++) stack_mem[depth_cnt-1][i] = product[i];
          end
        end
        res.index = idx;
        res.depth = 5'(depth_cnt);
        expected_results.push_back(res);
      end
      OP_POP: begin
        pop_items++;
        if (depth_cnt == 0) begin
          res.stat = ST_EMPTY;
          empty_hits++;
        end else begin
          depth_cnt--;
        end
        res.depth = 5'(depth_cnt);
        expected_results.push_back(res);
      end
      default: begin
        read_items++;
        res.depth = 5'(depth_cnt);
        if (depth_cnt == 0) begin
          res.stat = ST_EMPTY;
          empty_hits++;
          expected_results.push_back(res);
        end else begin
          for (i = 0; i < 16; i++) begin
            res.value = stack_mem[depth_cnt-1][i];
            res.index = 4'(i);
            res.last = (i == 15);
            expected_results.push_back(res);
          end
        end
      end
    endcase
  endtask

  // send one transaction, with bursts and random gaps before it
  task automatic send_item(input logic [1:0] op, input logic [3:0] idx,
                           input logic signed [31:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gaps_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    operation <= op;
    element_index <= idx;
    element_value <= val;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    items_sent++;
    update_stack_model(op, idx, val);
  endtask

  // hold off the sender until every expected result has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] extreme_value(input int sel);
    case (sel)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return FIX_ONE;
      default: return -FIX_ONE;
    endcase
  endfunction

  // mostly small q16.16 values, some full range and extremes
  function automatic logic signed [31:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return extreme_value($urandom_range(0, 5));
    if (r <= 3) return $urandom;
    return int'($urandom_range(0, 524288)) - 262144;
  endfunction

  task automatic send_matrix(input logic [1:0] op, input int count);
    int i;
    for (i = 0; i < count; i++) send_item(op, 4'(i), pick_value());
  endtask

  task automatic send_control(input logic [1:0] op);
    send_item(op, 4'($urandom_range(0, 15)), $urandom);
  endtask

  // field compare with report
  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  task automatic check_result();
    stack_result_t exp_r;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result expected none actual value %0h index %0d",
               $time, result_value, result_index);
      error_count++;
    end else begin
      exp_r = expected_results.pop_front();
      results_checked++;
      report_field("result_value", exp_r.value, result_value);
      report_field("result_index", 32'(exp_r.index), 32'(result_index));
      report_field("last_of_run", 32'(exp_r.last), 32'(last_of_run));
      report_field("status", 32'(exp_r.stat), 32'(status));
      report_field("depth_in_use", 32'(exp_r.depth), 32'(depth_in_use));
    end
  endtask

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) check_result();
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (run_left == 0) begin
          run_left = $urandom_range(1, 12);
          stall_level = ~stall_level;
        end else begin
          run_left--;
        end
        result_stall <= stall_level;
      end
    endcase
  end

  // run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("%0t: timeout after %0d cycles, %0d results outstanding",
             $time, cycle_count, expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic do_reset();
    int i, j;
    for (i = 0; i < STACK_DEPTH; i++)
      for (j = 0; j < 16; j++) stack_mem[i][j] = '0;
    for (j = 0; j < 16; j++) pending_m[j] = '0;
    for (j = 0; j < 4; j++) stack_mem[0][j*5] = FIX_ONE;
    depth_cnt = 1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
  endtask

  // identity left by reset
  task automatic test_reset_top();
    send_control(OP_READ);
    wait_drained();
  endtask

  // full push of a matrix of extreme values, then read it back
  task automatic test_push_extremes();
    int i;
    for (i = 0; i < 16; i++) send_item(OP_PUSH, 4'(i), extreme_value(i % 6));
    send_control(OP_READ);
    wait_drained();
  endtask

  // saturating multiply on the buffered extremes, then a multiply by identity
  task automatic test_multiply_saturate();
    int i;
    send_item(OP_MUL, LAST_ELEM, extreme_value(3));
    send_control(OP_READ);
    for (i = 0; i < 16; i++)
      send_item(OP_MUL, 4'(i), (i % 5 == 0) ? FIX_ONE : 32'sd0);
    send_control(OP_READ);
    wait_drained();
  endtask

  // push single final elements until full, then one push too many
  task automatic test_fill_to_full();
    while (depth_cnt < STACK_DEPTH) send_item(OP_PUSH, LAST_ELEM, pick_value());
    send_item(OP_PUSH, LAST_ELEM, pick_value());
    send_control(OP_READ);
    wait_drained();
  endtask

  // pop past the bottom, then read and multiply on an empty stack, push once and read
  task automatic test_drain_to_empty();
    gaps_on = 1'b0;
    while (depth_cnt > 0) send_control(OP_POP);
    send_control(OP_POP);
    send_control(OP_READ);
    send_item(OP_MUL, 4'd3, pick_value());
    send_item(OP_MUL, LAST_ELEM, pick_value());
    send_item(OP_PUSH, LAST_ELEM, pick_value());
    send_control(OP_READ);
    gaps_on = 1'b1;
    wait_drained();
  endtask

  // mostly whole matrices with random content, plus control and broken sequences
  task automatic test_random_mix();
    int start_count, r;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) gaps_on = ~gaps_on;
      if ($urandom_range(0, 39) == 0) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 22) begin
        send_matrix(OP_PUSH, 16);
      end else if (r < 40) begin
        send_matrix(OP_MUL, 16);
      end else if (r < 52) begin
        send_item($urandom_range(0, 1) ? OP_MUL : OP_PUSH, LAST_ELEM, pick_value());
      end else if (r < 67) begin
        send_control(OP_READ);
      end else if (r < 82) begin
        if (depth_cnt > 2 || $urandom_range(0, 3) == 0) send_control(OP_POP);
        else send_matrix(OP_PUSH, 16);
      end else if (r < 90) begin
        // aborted matrix followed by something else
        send_matrix($urandom_range(0, 1) ? OP_MUL : OP_PUSH, $urandom_range(1, 14));
        send_control(2'($urandom_range(2, 3)));
      end else begin
        send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), $urandom);
      end
    end
    wait_drained();
  endtask

  initial begin
    do_reset();
    test_reset_top();
    test_push_extremes();
    test_multiply_saturate();
    test_fill_to_full();
    test_drain_to_empty();
    test_random_mix();
    wait_drained();
    repeat (20) @(posedge clk);
    $display("run: %0d transactions (%0d push, %0d multiply elements, %0d pop, %0d read)",
             items_sent, push_elems, mul_elems, pop_items, read_items);
    $display("run: %0d results checked, %0d full and %0d empty cases, %0d errors",
             results_checked, full_hits, empty_hits, error_count);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
